// ===== src/stereo_lr8_multiband_crossover_core_assert.svh =====
// assertion macros for the crossover core
`ifndef STEREO_LR8_MULTIBAND_CROSSOVER_CORE_ASSERT_SVH
`define STEREO_LR8_MULTIBAND_CROSSOVER_CORE_ASSERT_SVH

// same-cycle implication
`define SLR8X_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("slr8x same-cycle check failed");

// next-cycle implication
`define SLR8X_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("slr8x next-cycle check failed");

`endif

// ===== src/slr8x_pkg.sv =====
package slr8x_pkg;

  localparam int NUM_SPLITS_DEF  = 3;
  localparam int STAGES_DEF      = 4;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 32;

  localparam int CNT_W       = 2;
  localparam int COEF_IDX_W  = 7;
  localparam int COEF_VAL_W  = 32;
  localparam int RESET_COUNT = 3;

  // Q8.32 state, coefficient product and sum widths
  localparam int ACC_W  = 40;
  localparam int PROD_W = 42;
  localparam int SUM_W  = 44;

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_COEF   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [2:0] TERM_B0 = 3'd0;
  localparam logic [2:0] TERM_B1 = 3'd1;
  localparam logic [2:0] TERM_B2 = 3'd2;
  localparam logic [2:0] TERM_A1 = 3'd3;
  localparam logic [2:0] TERM_A2 = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_RD,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_CEND,
    ST_OUT
  } state_t;

  typedef enum logic {
    PH_MAIN,
    PH_COMP
  } phase_t;

endpackage

// ===== src/slr8x_if.sv =====
interface slr8x_in_if import slr8x_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic [COEF_IDX_W-1:0]         coef_index;
  logic signed [COEF_VAL_W-1:0]  coef_value;

  modport source (output valid, mode, left_sample, right_sample, coef_index, coef_value,
                  input ready);
  modport sink (input valid, mode, left_sample, right_sample, coef_index, coef_value,
                output ready);
endinterface

interface slr8x_out_if import slr8x_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    band_index;
  logic signed [SAMPLE_BITS-1:0] left_band;
  logic signed [SAMPLE_BITS-1:0] right_band;
  logic                          last_band;

  modport source (output valid, band_index, left_band, right_band, last_band, input ready);
  modport sink (input valid, band_index, left_band, right_band, last_band, output ready);
endinterface

// ===== src/stereo_lr8_multiband_crossover_core.sv =====
// Stereo 8th-order Linkwitz-Riley crossover, active split count plus one bands per sample.
// Every biquad term runs on one shared coefficient multiplier: a term passes through the
// coefficient/state memory read, operand setup, two 32x20 partial products, round and
// accumulate. A biquad runs its b0, b1, b2, a1 and a2 terms in turn, each cascade of S stages
// ends in a closing state, and each lowpass/highpass pair begins with a start state. With n
// active splits a sample runs 4n main cascades plus 2n(n-1) compensator cascades, then one
// output per band; the output waits while the receiver stalls. Filter state sits in one
// single-port memory with a valid flag per word, so clearing is immediate and a word never
// written reads as zero.
`include "stereo_lr8_multiband_crossover_core_assert.svh"

module stereo_lr8_multiband_crossover_core import slr8x_pkg::*; #(
  parameter int NUM_SPLITS        = NUM_SPLITS_DEF,
  parameter int STAGES_PER_FILTER = STAGES_DEF,
  parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF,
  parameter int COEF_BITS         = COEF_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  slr8x_in_if.sink         in_ch,
  slr8x_out_if.source      out_ch,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  // geometry
  localparam int S         = STAGES_PER_FILTER;
  localparam int COEF_D    = NUM_SPLITS * 2 * S * 5;
  localparam int COMP_CNT  = (NUM_SPLITS * (NUM_SPLITS - 1)) / 2;
  localparam int MAIN_GRP  = NUM_SPLITS * 4;
  localparam int ST_D      = (MAIN_GRP + COMP_CNT * 4) * S * 2;
  localparam int CAW       = $clog2(COEF_D);
  localparam int SAW       = $clog2(ST_D);
  localparam int BW        = $clog2(NUM_SPLITS + 1);
  localparam int STW       = (S > 1) ? $clog2(S) : 1;
  localparam int CF        = COEF_BITS - 2;
  localparam int IS        = 33 - SAMPLE_BITS;
  localparam int MSW       = COEF_BITS + 41;
  localparam int RST_CNT   = (RESET_COUNT > NUM_SPLITS) ? NUM_SPLITS : RESET_COUNT;

  localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'((64'sd1 <<< (ACC_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);

  // saturate a wide sum to the 40-bit state format
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
    if (v > ACC_MAX) return ACC_MAX[ACC_W-1:0];
    if (v < ACC_MIN) return ACC_MIN[ACC_W-1:0];
    return v[ACC_W-1:0];
  endfunction

  // round half up to sample precision and saturate
  function automatic logic signed [SAMPLE_BITS-1:0] to_sample(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W+1:0] rs;
    logic signed [ACC_W+1:0] smax;
    logic signed [ACC_W+1:0] smin;
    smax = (ACC_W+2)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    smin = -smax - (ACC_W+2)'(1);
    rs   = ((ACC_W+2)'(v) + (ACC_W+2)'(64'sd1 <<< (IS - 1))) >>> IS;
    if (rs > smax) return smax[SAMPLE_BITS-1:0];
    if (rs < smin) return smin[SAMPLE_BITS-1:0];
    return rs[SAMPLE_BITS-1:0];
  endfunction

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [BW-1:0]  cnt_r;
  logic [BW-1:0]  sp_r, sp_nxt;
  logic [BW-1:0]  b_r, b_nxt;
  logic           ch_r, ch_nxt;
  logic           kind_r;
  logic [STW-1:0] stg_r;
  logic [2:0]     term_r;
  logic           go_out;

  // per-sample working values
  logic signed [ACC_W-1:0] rem_r  [2];
  logic signed [ACC_W-1:0] band_r [NUM_SPLITS+1][2];
  logic signed [ACC_W-1:0] casc_x_r, xs_r, t_r, lp_r, s1_r, s2_r;
  logic signed [PROD_W-1:0] acc1_r, acc2_r;

  // multiplier pipe
  logic                     mneg_r;
  logic [COEF_BITS-1:0]     ma_r;
  logic [ACC_W-1:0]         mb_r;
  logic [COEF_BITS+19:0]    ph_r, pl_r;
  logic [MSW-1:0]           msum;
  logic signed [PROD_W-1:0] prod;

  // memories
  logic signed [COEF_BITS-1:0] coef_mem [COEF_D];
  logic signed [COEF_BITS-1:0] coef_q_r;
  logic [CAW-1:0]              coef_addr;
  logic                        coef_we;
  logic signed [ACC_W-1:0]     st_mem [ST_D];
  logic signed [ACC_W-1:0]     st_q_r, st_wdata;
  logic                        st_v_r, st_we;
  logic [SAW-1:0]              st_addr;
  logic [ST_D-1:0]             vld_r;
  logic                        clr;

  logic in_acc, out_load;
  logic signed [ACC_W-1:0] out_l, out_r;
  logic signed [COEF_BITS-1:0] cval;
  logic signed [ACC_W-1:0] mval;

  logic                          out_valid_r;
  logic [1:0]                    out_band_r;
  logic signed [SAMPLE_BITS-1:0] out_left_r, out_right_r;
  logic                          out_last_r;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign in_acc            = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.band_index = out_band_r;
  assign out_ch.left_band  = out_left_r;
  assign out_ch.right_band = out_right_r;
  assign out_ch.last_band  = out_last_r;

  assign coef_we = in_acc && (in_ch.mode == MODE_COEF) && (int'(in_ch.coef_index) < COEF_D);
  assign clr     = cfg_we || coef_we || (in_acc && (in_ch.mode == MODE_CLEAR));

  // coefficient and state addressing from the loop counters
  always_comb begin
    int grp;
    int ci;
    int w;
    ci = ((int'(sp_r) * (int'(sp_r) - 1)) >> 1) + int'(b_r);
    if (phase_r == PH_MAIN) begin
      grp = (int'(sp_r) * 2 + int'(kind_r)) * 2 + int'(ch_r);
    end else begin
      grp = MAIN_GRP + (ci * 2 + int'(kind_r)) * 2 + int'(ch_r);
    end
    // s1 is read on b0 and written on a1, s2 read on b1 and written on a2
    w = ((term_r == TERM_B0) || (term_r == TERM_A1)) ? 0 : 1;
    st_addr   = SAW'((grp * S + int'(stg_r)) * 2 + w);
    coef_addr = in_acc ? CAW'(in_ch.coef_index)
                       : CAW'(((int'(sp_r) * 2 + int'(kind_r)) * S + int'(stg_r)) * 5
                              + int'(term_r));
  end

  // rounded, signed coefficient product
  always_comb begin
    logic [PROD_W-1:0] q;
    msum = (MSW'(ph_r) << 20) + MSW'(pl_r) + (MSW'(1) << (CF - 1));
    q    = msum[CF +: PROD_W];
    prod = mneg_r ? -$signed(q) : $signed(q);
  end

  // state memory write on the a1 and a2 terms
  always_comb begin
    st_we    = (state_r == ST_MUL3) && ((term_r == TERM_A1) || (term_r == TERM_A2));
    st_wdata = (term_r == TERM_A1)
             ? sat_acc(SUM_W'(acc1_r) - SUM_W'(prod) + SUM_W'(s2_r))
             : sat_acc(SUM_W'(acc2_r) - SUM_W'(prod));
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_addr] <= in_ch.coef_value[COEF_BITS-1:0];
    end
    coef_q_r <= coef_mem[coef_addr];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_addr] <= st_wdata;
    end
    st_q_r <= st_mem[st_addr];
    st_v_r <= vld_r[st_addr];
  end

  // one valid flag per state word, cleared at once
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else if (st_we) begin
      vld_r[st_addr] <= 1'b1;
    end
  end

  // next job after a finished lowpass/highpass pair
  always_comb begin
    phase_nxt = phase_r;
    sp_nxt    = sp_r;
    b_nxt     = b_r;
    ch_nxt    = 1'b0;
    go_out    = 1'b0;
    if (!ch_r) begin
      ch_nxt = 1'b1;
    end else if (int'(sp_r) + 1 < int'(cnt_r)) begin
      sp_nxt = sp_r + BW'(1);
    end else if (phase_r == PH_MAIN) begin
      if (int'(cnt_r) >= 2) begin
        phase_nxt = PH_COMP;
        b_nxt     = '0;
        sp_nxt    = BW'(1);
      end else begin
        go_out = 1'b1;
        b_nxt  = '0;
      end
    end else if (int'(b_r) + 2 < int'(cnt_r)) begin
      b_nxt  = b_r + BW'(1);
      sp_nxt = b_r + BW'(2);
    end else begin
      go_out = 1'b1;
      b_nxt  = '0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.mode == MODE_SAMPLE)) begin
          state_nxt = (cnt_r == '0) ? ST_OUT : ST_START;
        end
      end
      ST_START: state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_MUL0;
      ST_MUL0:  state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_MUL3;
      ST_MUL3: begin
        if ((term_r == TERM_A2) && (int'(stg_r) == S - 1)) begin
          state_nxt = ST_CEND;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_CEND: begin
        if (!kind_r) begin
          state_nxt = ST_RD;
        end else begin
          state_nxt = go_out ? ST_OUT : ST_START;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load = 1'b1;
          if (b_r == cnt_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= BW'(RST_CNT);
      phase_r <= PH_MAIN;
      sp_r    <= '0;
      b_r     <= '0;
      ch_r    <= 1'b0;
      kind_r  <= 1'b0;
      stg_r   <= '0;
      term_r  <= TERM_B0;
    end else begin
      if (cfg_we) begin
        cnt_r <= (int'(cfg_wdata) > NUM_SPLITS) ? BW'(NUM_SPLITS) : BW'(cfg_wdata);
      end
      case (state_r)
        ST_IDLE: begin
          phase_r <= PH_MAIN;
          sp_r    <= '0;
          b_r     <= '0;
          ch_r    <= 1'b0;
        end
        ST_START: begin
          kind_r <= 1'b0;
          stg_r  <= '0;
          term_r <= TERM_B0;
        end
        ST_MUL3: begin
          if (term_r == TERM_A2) begin
            term_r <= TERM_B0;
            if (int'(stg_r) != S - 1) begin
              stg_r <= stg_r + STW'(1);
            end
          end else begin
            term_r <= term_r + 3'd1;
          end
        end
        ST_CEND: begin
          if (!kind_r) begin
            kind_r <= 1'b1;
            stg_r  <= '0;
            term_r <= TERM_B0;
          end else begin
            phase_r <= phase_nxt;
            sp_r    <= sp_nxt;
            b_r     <= b_nxt;
            ch_r    <= ch_nxt;
          end
        end
        ST_OUT: begin
          if (out_load && (b_r != cnt_r)) begin
            b_r <= b_r + BW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  assign cval = coef_q_r;
  assign mval = (term_r < TERM_A1) ? xs_r : t_r;

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rem_r[0] <= ACC_W'(in_ch.left_sample) <<< IS;
          rem_r[1] <= ACC_W'(in_ch.right_sample) <<< IS;
        end
      end
      ST_START: begin
        if (phase_r == PH_MAIN) begin
          casc_x_r <= rem_r[ch_r];
          xs_r     <= rem_r[ch_r];
        end else begin
          casc_x_r <= band_r[b_r][ch_r];
          xs_r     <= band_r[b_r][ch_r];
        end
      end
      ST_MUL0: begin
        mneg_r <= (cval < 0) != (mval < 0);
        ma_r   <= (cval < 0) ? COEF_BITS'(-cval) : COEF_BITS'(cval);
        mb_r   <= (mval < 0) ? ACC_W'(-mval) : ACC_W'(mval);
        if (term_r == TERM_B0) begin
          s1_r <= st_v_r ? st_q_r : '0;
        end
        if (term_r == TERM_B1) begin
          s2_r <= st_v_r ? st_q_r : '0;
        end
      end
      ST_MUL1: ph_r <= (COEF_BITS+20)'(ma_r) * (COEF_BITS+20)'(mb_r[ACC_W-1:20]);
      ST_MUL2: pl_r <= (COEF_BITS+20)'(ma_r) * (COEF_BITS+20)'(mb_r[19:0]);
      ST_MUL3: begin
        case (term_r)
          TERM_B0: t_r    <= sat_acc(SUM_W'(prod) + SUM_W'(s1_r));
          TERM_B1: acc1_r <= prod;
          TERM_B2: acc2_r <= prod;
          TERM_A2: xs_r   <= t_r;
          default: ;
        endcase
      end
      ST_CEND: begin
        if (!kind_r) begin
          // highpass branch reuses the cascade input
          xs_r <= casc_x_r;
          if (phase_r == PH_MAIN) begin
            band_r[sp_r][ch_r] <= xs_r;
          end else begin
            lp_r <= xs_r;
          end
        end else if (phase_r == PH_MAIN) begin
          rem_r[ch_r] <= xs_r;
        end else begin
          // allpass compensator: lowpass plus highpass
          band_r[b_r][ch_r] <= sat_acc(SUM_W'(lp_r) + SUM_W'(xs_r));
        end
      end
      default: ;
    endcase
  end

  // output register, top band comes from the remainder
  assign out_l = (b_r == cnt_r) ? rem_r[0] : band_r[b_r][0];
  assign out_r = (b_r == cnt_r) ? rem_r[1] : band_r[b_r][1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_band_r  <= 2'(b_r);
      out_left_r  <= to_sample(out_l);
      out_right_r <= to_sample(out_r);
      out_last_r  <= (b_r == cnt_r);
    end
  end

  // checks
  `SLR8X_ASSERT_NEXT(a_busy_after_sample, clk, rst_n, in_acc && (in_ch.mode == MODE_SAMPLE), !in_ch.ready)
  `SLR8X_ASSERT_SAME(a_band_in_range, clk, rst_n, out_ch.valid, int'(out_ch.band_index) <= int'(cnt_r))
  `SLR8X_ASSERT_SAME(a_last_is_top, clk, rst_n, out_ch.valid && out_ch.last_band, int'(out_ch.band_index) == int'(cnt_r))

endmodule
